// File: rtl/core/nsag_pkg.sv
package nsag_pkg;

  // Array shape and field widths
  localparam int NDIM        = 3;
  localparam int DIGIT_W     = 16;
  localparam int EXTENT_W    = 16;
  localparam int STRIDE_W    = 32;
  localparam int AMOUNT_W    = 32;
  localparam int ADDR_W      = 48;
  localparam int OUT_DIGIT_W = 16;
  localparam int OUT_DIGITS  = 3;
  localparam int KIND_W      = 2;
  localparam int TDIM_W      = 2;
  localparam int STATUS_W    = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int CFG_DIMS   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_EXTENT0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE    = 3'd6;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_STEP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEEK = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ADD  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_INSIDE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_END    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

  // Working value: widest start value plus one bit of carry growth per dimension
  localparam int WORK_BASE_W = (DIGIT_W > AMOUNT_W) ? DIGIT_W : AMOUNT_W;
  localparam int WORK_W      = WORK_BASE_W + NDIM;

  // Serial divider inside each cell: DIV_BITS quotient bits per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = (WORK_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W     = DIV_STEPS * DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int DIM_W    = (NDIM > 1) ? $clog2(NDIM) : 1;
  localparam int SETTLE_W = $clog2(NDIM + 1);

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [AMOUNT_W-1:0] amount;
    logic [TDIM_W-1:0]   target_dim;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]      address;
    logic [OUT_DIGIT_W-1:0] digit0;
    logic [OUT_DIGIT_W-1:0] digit1;
    logic [OUT_DIGIT_W-1:0] digit2;
    logic [STATUS_W-1:0]    status;
  } out_item_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic                load;
    logic                keep_digit;
    logic [AMOUNT_W-1:0] addend;
    logic                start;
    logic                commit;
  } cell_ctrl_t;

endpackage

// File: rtl/core/nsag_cell.sv
module nsag_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  nsag_pkg::cell_ctrl_t            ctrl,
  input  logic [nsag_pkg::EXTENT_W-1:0]   extent,
  input  logic [nsag_pkg::STRIDE_W-1:0]   stride,
  input  logic                            carry_valid,
  input  logic [nsag_pkg::WORK_W-1:0]     carry,
  input  logic [nsag_pkg::ADDR_W-1:0]     psum_in,
  output logic [nsag_pkg::WORK_W-1:0]     work,
  output logic [nsag_pkg::DIGIT_W-1:0]    digit,
  output logic [nsag_pkg::WORK_W-1:0]     quotient,
  output logic                            done,
  output logic [nsag_pkg::ADDR_W-1:0]     psum
);

  localparam logic [nsag_pkg::DIV_CNT_W-1:0] DIV_LAST =
    nsag_pkg::DIV_CNT_W'(nsag_pkg::DIV_STEPS - 1);

  logic [nsag_pkg::DIV_W-1:0]                     div_acc;
  logic [nsag_pkg::EXTENT_W-1:0]                  div_rem;
  logic [nsag_pkg::DIV_W-1:0]                     acc_next;
  logic [nsag_pkg::EXTENT_W-1:0]                  rem_next;
  logic [nsag_pkg::EXTENT_W:0]                    trial;
  logic                                           busy;
  logic [nsag_pkg::DIV_CNT_W-1:0]                 cnt;
  logic [nsag_pkg::DIGIT_W+nsag_pkg::STRIDE_W-1:0] prod_full;
  logic [nsag_pkg::ADDR_W-1:0]                    prod;

  // Restoring division: shift in DIV_BITS dividend bits, one trial subtract each
  always_comb begin
    acc_next = div_acc;
    rem_next = div_rem;
    trial    = '0;
    for (int i = 0; i < nsag_pkg::DIV_BITS; i++) begin
      trial    = {rem_next, acc_next[nsag_pkg::DIV_W-1]};
      acc_next = {acc_next[nsag_pkg::DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, extent}) begin
        trial       = trial - {1'b0, extent};
        acc_next[0] = 1'b1;
      end
      rem_next = trial[nsag_pkg::EXTENT_W-1:0];
    end
  end

  // Divider control and committed digit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      cnt   <= '0;
      done  <= 1'b0;
      digit <= '0;
    end else begin
      // Pulse done as the last quotient bits go in
      done <= busy && !ctrl.start && (cnt == DIV_LAST);
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          busy <= 1'b0;
        end
      end
      if (ctrl.commit) begin
        digit <= work[nsag_pkg::DIGIT_W-1:0];
      end
    end
  end

  // Working value: load, take the neighbor's carry, keep the remainder
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      work <= (ctrl.keep_digit ? nsag_pkg::WORK_W'(digit) : '0)
              + nsag_pkg::WORK_W'(ctrl.addend);
    end else if (carry_valid) begin
      work <= work + carry;
    end else if (busy && (cnt == DIV_LAST)) begin
      work <= nsag_pkg::WORK_W'(rem_next);
    end
    if (ctrl.start) begin
      div_acc <= nsag_pkg::DIV_W'(work);
      div_rem <= '0;
    end else if (busy) begin
      div_acc <= acc_next;
      div_rem <= rem_next;
    end
  end

  assign quotient = div_acc[nsag_pkg::WORK_W-1:0];

  // Address term of this dimension, accumulated along the chain
  assign prod_full = digit * stride;

  always_ff @(posedge clk) begin
    prod <= nsag_pkg::ADDR_W'(prod_full);
    psum <= psum_in + prod;
  end

endmodule

// File: rtl/core/ndim_strided_address_generator_core.sv
// A step, seek or add passes S_START and S_WAIT for each dimension but the outermost,
// from the innermost outward, then S_CHECK, S_SETTLE and S_EMIT; an item that does not
// move goes straight to S_SETTLE and S_EMIT. Items are taken one at a time: a new one is
// accepted only once the last result is on the output. Each cell has a 4-bit-per-cycle divider.
// Reset (rst, synchronous): index digits zero, extents 1, strides and base 0, output empty.
module ndim_strided_address_generator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  nsag_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output nsag_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [nsag_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nsag_pkg::CFG_DATA_W-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_CHECK,
    S_SETTLE,
    S_EMIT
  } state_t;

  localparam logic [nsag_pkg::SETTLE_W-1:0] SETTLE_LAST = nsag_pkg::SETTLE_W'(nsag_pkg::NDIM);

  state_t                                state;
  logic [nsag_pkg::DIM_W-1:0]            dim;
  logic [nsag_pkg::SETTLE_W-1:0]         settle_cnt;
  logic                                  reject;

  logic [nsag_pkg::EXTENT_W-1:0]         extent  [nsag_pkg::NDIM];
  logic [nsag_pkg::EXTENT_W-1:0]         ext_eff [nsag_pkg::NDIM];
  logic [nsag_pkg::STRIDE_W-1:0]         stride  [nsag_pkg::NDIM];
  logic [nsag_pkg::ADDR_W-1:0]           base;

  nsag_pkg::cell_ctrl_t                  ctrl       [nsag_pkg::NDIM];
  logic [nsag_pkg::WORK_W-1:0]           cell_work  [nsag_pkg::NDIM];
  logic [nsag_pkg::DIGIT_W-1:0]          cell_digit [nsag_pkg::NDIM];
  logic [nsag_pkg::WORK_W-1:0]           cell_quo   [nsag_pkg::NDIM];
  logic [nsag_pkg::ADDR_W-1:0]           cell_psum  [nsag_pkg::NDIM];
  logic [nsag_pkg::NDIM-1:0]             cell_done;

  logic [nsag_pkg::OUT_DIGIT_W-1:0]      digit_pad [nsag_pkg::OUT_DIGITS];
  logic                                  accept;
  logic                                  move;
  logic                                  inner_zero;
  logic                                  fits;
  logic                                  at_end;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign move     = (in_data.kind == nsag_pkg::KIND_STEP)
                 || (in_data.kind == nsag_pkg::KIND_SEEK)
                 || ((in_data.kind == nsag_pkg::KIND_ADD)
                     && (int'(in_data.target_dim) < nsag_pkg::NDIM));

  // Hold configuration registers; ignore unused indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < nsag_pkg::NDIM; d++) begin
        extent[d] <= nsag_pkg::EXTENT_W'(1);
        stride[d] <= '0;
      end
      base <= '0;
    end else if (cfg_we) begin
      for (int d = 0; d < nsag_pkg::NDIM; d++) begin
        if (d < nsag_pkg::CFG_DIMS) begin
          if (cfg_index == nsag_pkg::REG_EXTENT0 + nsag_pkg::CFG_IDX_W'(d)) begin
            extent[d] <= cfg_data[nsag_pkg::EXTENT_W-1:0];
          end
          if (cfg_index == nsag_pkg::REG_STRIDE0 + nsag_pkg::CFG_IDX_W'(d)) begin
            stride[d] <= cfg_data[nsag_pkg::STRIDE_W-1:0];
          end
        end
      end
      if (cfg_index == nsag_pkg::REG_BASE) begin
        base <= cfg_data[nsag_pkg::ADDR_W-1:0];
      end
    end
  end

  // Treat a zero extent as one
  always_comb begin
    for (int d = 0; d < nsag_pkg::NDIM; d++) begin
      ext_eff[d] = (extent[d] == '0) ? nsag_pkg::EXTENT_W'(1) : extent[d];
    end
  end

  // Drive cell controls; a seek loads the element number into the innermost cell
  always_comb begin
    for (int d = 0; d < nsag_pkg::NDIM; d++) begin
      ctrl[d].load       = accept;
      ctrl[d].keep_digit = (in_data.kind != nsag_pkg::KIND_SEEK);
      ctrl[d].addend     = '0;
      ctrl[d].start      = (state == S_START) && (dim == nsag_pkg::DIM_W'(d));
      ctrl[d].commit     = (state == S_CHECK) && fits;
    end
    unique case (in_data.kind)
      nsag_pkg::KIND_STEP: begin
        ctrl[nsag_pkg::NDIM-1].addend = nsag_pkg::AMOUNT_W'(1);
      end
      nsag_pkg::KIND_SEEK: begin
        ctrl[nsag_pkg::NDIM-1].addend = in_data.amount;
      end
      nsag_pkg::KIND_ADD: begin
        for (int d = 0; d < nsag_pkg::NDIM; d++) begin
          if (int'(in_data.target_dim) == d) begin
            ctrl[d].addend = in_data.amount;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // End test on the normalized digits
  always_comb begin
    inner_zero = 1'b1;
    for (int d = 1; d < nsag_pkg::NDIM; d++) begin
      if (cell_work[d] != '0) begin
        inner_zero = 1'b0;
      end
    end
    fits = (cell_work[0] < nsag_pkg::WORK_W'(ext_eff[0]))
        || ((cell_work[0] == nsag_pkg::WORK_W'(ext_eff[0])) && inner_zero);
  end

  // Pad digits to the three result fields
  always_comb begin
    for (int d = 0; d < nsag_pkg::OUT_DIGITS; d++) begin
      digit_pad[d] = '0;
    end
    for (int d = 0; d < nsag_pkg::NDIM; d++) begin
      if (d < nsag_pkg::OUT_DIGITS) begin
        digit_pad[d] = nsag_pkg::OUT_DIGIT_W'(cell_digit[d]);
      end
    end
  end

  assign at_end = nsag_pkg::WORK_W'(cell_digit[0]) >= nsag_pkg::WORK_W'(ext_eff[0]);

  // Sequence the carry chain, then settle the address sum and emit the item
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      dim        <= '0;
      settle_cnt <= '0;
      reject     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Drop a taken item unless a new one replaces it below
      if (out_valid && out_ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            reject     <= 1'b0;
            settle_cnt <= '0;
            if (!move) begin
              state <= S_SETTLE;
            end else if (nsag_pkg::NDIM > 1) begin
              dim   <= nsag_pkg::DIM_W'(nsag_pkg::NDIM - 1);
              state <= S_START;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (cell_done[dim]) begin
            if (dim == nsag_pkg::DIM_W'(1)) begin
              state <= S_CHECK;
            end else begin
              dim   <= dim - 1'b1;
              state <= S_START;
            end
          end
        end
        S_CHECK: begin
          reject     <= !fits;
          settle_cnt <= '0;
          state      <= S_SETTLE;
        end
        S_SETTLE: begin
          settle_cnt <= settle_cnt + 1'b1;
          if (settle_cnt == SETTLE_LAST) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            out_data.address <= cell_psum[nsag_pkg::NDIM-1];
            out_data.digit0  <= digit_pad[0];
            out_data.digit1  <= digit_pad[1];
            out_data.digit2  <= digit_pad[2];
            out_data.status  <= reject ? nsag_pkg::STATUS_REJECT
                              : (at_end ? nsag_pkg::STATUS_END : nsag_pkg::STATUS_INSIDE);
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Row of cells, innermost dimension last; quotients carry toward dimension zero
  for (genvar g = 0; g < nsag_pkg::NDIM; g++) begin : g_cell
    logic                          carry_valid;
    logic [nsag_pkg::WORK_W-1:0]   carry;
    logic [nsag_pkg::ADDR_W-1:0]   psum_in;

    if (g == nsag_pkg::NDIM - 1) begin : g_last
      assign carry_valid = 1'b0;
      assign carry       = '0;
    end else begin : g_inner
      assign carry_valid = cell_done[g+1];
      assign carry       = cell_quo[g+1];
    end

    if (g == 0) begin : g_first
      assign psum_in = base;
    end else begin : g_rest
      assign psum_in = cell_psum[g-1];
    end

    nsag_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl[g]),
      .extent      (ext_eff[g]),
      .stride      (stride[g]),
      .carry_valid (carry_valid),
      .carry       (carry),
      .psum_in     (psum_in),
      .work        (cell_work[g]),
      .digit       (cell_digit[g]),
      .quotient    (cell_quo[g]),
      .done        (cell_done[g]),
      .psum        (cell_psum[g])
    );
  end

endmodule

// File: rtl/core/nsag_checker.sv
module nsag_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  nsag_pkg::out_item_t               out_data
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One item at a time: an accept closes the input for the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input stayed open after an accept");

  // A new result appears only as the block returns to idle
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while an item is still in work");

  // Reset leaves the block idle and the output empty
  a_reset: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

endmodule

bind ndim_strided_address_generator_core nsag_checker u_checker (.*);
